/* sv/two_key_stepping_letter_cipher_unit_assert.svh */
// Assertion macros for the two-key stepping letter cipher unit.
// Both sample on clock; the first is quiet while reset is high.
`ifndef TWO_KEY_STEPPING_LETTER_CIPHER_UNIT_ASSERT_SVH
`define TWO_KEY_STEPPING_LETTER_CIPHER_UNIT_ASSERT_SVH

// check prop at every clock edge outside reset
`define TKSLC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check prop at every clock edge, reset included
`define TKSLC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* sv/tkslc_pkg.sv */
// Shared types, constants and mod-26 helpers for the letter cipher.
// Used by every module of the block but tkslc_ram; depends on nothing.
package tkslc_pkg;

   localparam int KEY_LEN = 26;
   localparam int KEY_AW = (KEY_LEN > 1) ? $clog2(KEY_LEN) : 1;
   localparam int LETTER_W = 5;
   localparam int OP_W = 2;

   localparam logic [LETTER_W-1:0] ALPHA = LETTER_W'(26);
   localparam logic [KEY_AW-1:0] KEY_LAST = KEY_AW'(KEY_LEN - 1);
   localparam logic [LETTER_W-1:0] KEY_LEN_L = LETTER_W'(KEY_LEN);

   typedef enum logic [OP_W-1:0] {
      OP_ENCODE      = 2'd0,
      OP_DECODE      = 2'd1,
      OP_LOAD_FIRST  = 2'd2,
      OP_LOAD_SECOND = 2'd3
   } op_type;

   typedef struct packed {
      logic                first_we;
      logic                second_we;
      logic [KEY_AW-1:0]   waddr;
      logic [LETTER_W-1:0] wdata;
      logic                re;
      logic [KEY_AW-1:0]   first_raddr;
      logic [KEY_AW-1:0]   second_raddr;
   } key_access_type;

   function automatic logic [LETTER_W-1:0] reduce26(input logic [LETTER_W-1:0] v);
      reduce26 = (v >= ALPHA) ? (v - ALPHA) : v;
   endfunction

   function automatic logic [LETTER_W-1:0] add26(input logic [LETTER_W-1:0] a,
                                                 input logic [LETTER_W-1:0] b);
      logic [LETTER_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, ALPHA}) begin
         s = s - {1'b0, ALPHA};
      end
      add26 = s[LETTER_W-1:0];
   endfunction

   function automatic logic [LETTER_W-1:0] sub26(input logic [LETTER_W-1:0] a,
                                                 input logic [LETTER_W-1:0] b);
      sub26 = (a >= b) ? (a - b) : (a + ALPHA - b);
   endfunction

endpackage

/* sv/tkslc_ram.sv */
// Generic single-write, single-read RAM with a registered, enabled read.
// Stand-alone; used for both key tables.
module tkslc_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 26
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic                             re,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/tkslc_sched.sv */
// Key position odometer and key table access decode.
// Depends on tkslc_pkg; drives the two key RAMs.
module tkslc_sched import tkslc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  op_type              operation,
   input  logic [LETTER_W-1:0] letter,
   input  logic [LETTER_W-1:0] key_index,
   input  logic                message_start,
   output key_access_type      access
);

   logic [KEY_AW-1:0] first_pos_ff, first_pos_in;
   logic [KEY_AW-1:0] second_pos_ff, second_pos_in;
   logic [KEY_AW-1:0] first_base, second_base;
   logic              first_wrap, cipher_op, load_ok;

   assign cipher_op = (operation == OP_ENCODE) || (operation == OP_DECODE);
   assign load_ok = key_index < KEY_LEN_L;
   assign first_base = message_start ? '0 : first_pos_ff;
   assign second_base = message_start ? '0 : second_pos_ff;
   assign first_wrap = first_base == KEY_LAST;

   always_comb begin
      first_pos_in = first_pos_ff;
      second_pos_in = second_pos_ff;
      if (accept && cipher_op) begin
         first_pos_in = first_wrap ? '0 : first_base + KEY_AW'(1);
         second_pos_in = second_base;
         if (first_wrap) begin
            second_pos_in = (second_base == KEY_LAST) ? '0 : second_base + KEY_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_pos_ff <= '0;
         second_pos_ff <= '0;
      end else begin
         first_pos_ff <= first_pos_in;
         second_pos_ff <= second_pos_in;
      end
   end

   always_comb begin
      access.first_we = accept && load_ok && (operation == OP_LOAD_FIRST);
      access.second_we = accept && load_ok && (operation == OP_LOAD_SECOND);
      access.waddr = key_index[KEY_AW-1:0];
      access.wdata = letter;
      access.re = accept && cipher_op;
      access.first_raddr = first_base;
      access.second_raddr = second_base;
   end

endmodule

/* sv/tkslc_mix.sv */
// Letter combine stage: adds or subtracts both key entries mod 26.
// Depends on tkslc_pkg for the mod-26 helpers.
module tkslc_mix import tkslc_pkg::*; (
   input  logic                decode,
   input  logic [LETTER_W-1:0] letter,
   input  logic [LETTER_W-1:0] first_entry,
   input  logic [LETTER_W-1:0] second_entry,
   output logic [LETTER_W-1:0] out_letter
);

   logic [LETTER_W-1:0] v, k1, k2, partial;

   always_comb begin
      v = reduce26(letter);
      k1 = reduce26(first_entry);
      k2 = reduce26(second_entry);
      if (decode) begin
         partial = sub26(v, k1);
         out_letter = sub26(partial, k2);
      end else begin
         partial = add26(v, k1);
         out_letter = add26(partial, k2);
      end
   end

endmodule

/* sv/two_key_stepping_letter_cipher_unit.sv */
// Two-key stepping letter cipher: letters 0..25 in, one letter out per encode or
// decode beat, nothing out for key loads. One beat is accepted every cycle while
// the result side keeps up; a result is registered in the key RAM read, then in
// the output register. Each cycle carries at most one key RAM access per table,
// a load write or a cipher read, which sets the one-beat-per-cycle rate.
// Key entries never loaded read as undefined. Positions reset to zero.
`include "two_key_stepping_letter_cipher_unit_assert.svh"
module two_key_stepping_letter_cipher_unit import tkslc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [LETTER_W-1:0] req_letter,
   input  logic [LETTER_W-1:0] req_key_index,
   input  logic                req_message_start,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [LETTER_W-1:0] rsp_out_letter
);

   key_access_type      access;
   op_type              operation;
   logic                accept, advance, cipher_op;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_decode_ff;
   logic [LETTER_W-1:0] s1_letter_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LETTER_W-1:0] rsp_letter_ff;
   logic [LETTER_W-1:0] first_entry, second_entry, mixed;

   assign operation = op_type'(req_operation);
   assign cipher_op = (operation == OP_ENCODE) || (operation == OP_DECODE);
   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept = req_valid && req_ready;

   tkslc_sched u_sched (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .operation     (operation),
      .letter        (req_letter),
      .key_index     (req_key_index),
      .message_start (req_message_start),
      .access        (access)
   );

   tkslc_ram #(.WIDTH(LETTER_W), .DEPTH(KEY_LEN)) u_first_key (
      .clock (clock),
      .we    (access.first_we),
      .waddr (access.waddr),
      .wdata (access.wdata),
      .re    (access.re),
      .raddr (access.first_raddr),
      .rdata (first_entry)
   );

   tkslc_ram #(.WIDTH(LETTER_W), .DEPTH(KEY_LEN)) u_second_key (
      .clock (clock),
      .we    (access.second_we),
      .waddr (access.waddr),
      .wdata (access.wdata),
      .re    (access.re),
      .raddr (access.second_raddr),
      .rdata (second_entry)
   );

   tkslc_mix u_mix (
      .decode       (s1_decode_ff),
      .letter       (s1_letter_ff),
      .first_entry  (first_entry),
      .second_entry (second_entry),
      .out_letter   (mixed)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_ready) begin
         s1_valid_in = accept && cipher_op;
      end
      if (advance) begin
         rsp_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_decode_ff <= operation == OP_DECODE;
         s1_letter_ff <= req_letter;
      end
      if (advance && s1_valid_ff) begin
         rsp_letter_ff <= mixed;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_letter = rsp_letter_ff;

   `TKSLC_ASSERT(a_rsp_in_range, rsp_valid_ff |-> (rsp_letter_ff < ALPHA), "result letter out of range")
   `TKSLC_ASSERT(a_s1_hold, (s1_valid_ff && rsp_valid_ff && !rsp_ready) |=> (s1_valid_ff && $stable(s1_letter_ff)), "stalled stage lost its beat")
   `TKSLC_ASSERT(a_cipher_enters, (accept && cipher_op) |=> s1_valid_ff, "cipher beat did not enter the read stage")
   `TKSLC_ASSERT_ALWAYS(a_reset_clears, reset |=> (!s1_valid_ff && !rsp_valid_ff), "reset left a beat in flight")

endmodule
